/* rtl/lcw_pkg.sv */
// ----------------------------------------------------------------------------
// lcw_pkg
// Shared types and constants for the line clip to window unit.
// ----------------------------------------------------------------------------
package lcw_pkg;

  // Coordinate width (signed integer)
  localparam int CW = 16;
  // Width of the product magnitude / dividend
  localparam int DW = 2 * CW;
  // Width of the divide step counter
  localparam int CNT_W = $clog2(DW + 1);
  // Width of the configuration register index
  localparam int IDX_W = 8;
  // Most intersection moves before giving up
  localparam int MAX_MOVES = 4;
  localparam int MOVE_W = $clog2(MAX_MOVES + 1);

  // Region outcode bits
  localparam logic [3:0] CODE_RIGHT  = 4'd8;
  localparam logic [3:0] CODE_LEFT   = 4'd2;
  localparam logic [3:0] CODE_TOP    = 4'd4;
  localparam logic [3:0] CODE_BOTTOM = 4'd1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_X_MIN = 8'd0;
  localparam logic [IDX_W-1:0] REG_X_MAX = 8'd1;
  localparam logic [IDX_W-1:0] REG_Y_MIN = 8'd2;
  localparam logic [IDX_W-1:0] REG_Y_MAX = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_UPDATE,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic div_step;
    logic update;
    logic finish;
    logic accept;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [3:0] c0;
    logic [3:0] c1;
    logic       div_done;
  } status_t;

endpackage

/* rtl/lcw_ctrl.sv */
// ----------------------------------------------------------------------------
// lcw_ctrl
// Sequencer: evaluates outcodes, runs intersection moves, hands out result.
// ----------------------------------------------------------------------------
module lcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  lcw_pkg::status_t status,
  output lcw_pkg::cmd_t    cmd
);

  lcw_pkg::state_t                 state, state_next;
  logic [lcw_pkg::MOVE_W-1:0]      moves, moves_next;

  // State and move count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcw_pkg::ST_IDLE;
      moves <= '0;
    end else begin
      state <= state_next;
      moves <= moves_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    moves_next = moves;
    cmd        = '0;
    case (state)
      lcw_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          moves_next = '0;
          state_next = lcw_pkg::ST_EVAL;
        end
      end
      lcw_pkg::ST_EVAL: begin
        if ((status.c0 | status.c1) == 4'd0) begin
          cmd.finish = 1'b1;
          cmd.accept = 1'b1;
          state_next = lcw_pkg::ST_OUT;
        end else if ((status.c0 & status.c1) != 4'd0 ||
                     moves == lcw_pkg::MOVE_W'(lcw_pkg::MAX_MOVES)) begin
          cmd.finish = 1'b1;
          state_next = lcw_pkg::ST_OUT;
        end else begin
          cmd.mul    = 1'b1;
          state_next = lcw_pkg::ST_MUL;
        end
      end
      lcw_pkg::ST_MUL: begin
        cmd.div_start = 1'b1;
        state_next    = lcw_pkg::ST_DIV;
      end
      lcw_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = lcw_pkg::ST_UPDATE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      lcw_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        moves_next = moves + 1'b1;
        state_next = lcw_pkg::ST_EVAL;
      end
      lcw_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = lcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lcw_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state != lcw_pkg::ST_IDLE);
  assign out_valid = (state == lcw_pkg::ST_OUT);

endmodule

/* rtl/lcw_dp.sv */
// ----------------------------------------------------------------------------
// lcw_dp
// Window registers, endpoint registers, multiplier, serial divider, output.
// ----------------------------------------------------------------------------
module lcw_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lcw_pkg::IDX_W-1:0]       cfg_index,
  input  logic [lcw_pkg::CW-1:0]          cfg_data,
  input  logic signed [lcw_pkg::CW-1:0]   start_x,
  input  logic signed [lcw_pkg::CW-1:0]   start_y,
  input  logic signed [lcw_pkg::CW-1:0]   end_x,
  input  logic signed [lcw_pkg::CW-1:0]   end_y,
  input  lcw_pkg::cmd_t                   cmd,
  output lcw_pkg::status_t                status,
  output logic                            accepted,
  output logic signed [lcw_pkg::CW-1:0]   clipped_start_x,
  output logic signed [lcw_pkg::CW-1:0]   clipped_start_y,
  output logic signed [lcw_pkg::CW-1:0]   clipped_end_x,
  output logic signed [lcw_pkg::CW-1:0]   clipped_end_y
);

  localparam int CW = lcw_pkg::CW;
  localparam int DW = lcw_pkg::DW;
  localparam int RW = CW + 2;

  logic signed [CW-1:0] wx_min, wx_max, wy_min, wy_max;
  logic signed [CW-1:0] x0, y0, x1, y1;

  // Latched per-move operands
  logic                 neg, first_r, vert_r;
  logic signed [CW-1:0] base_r, edge_r;
  logic [CW:0]          divisor;
  logic [DW-1:0]        prod;
  logic [DW-1:0]        dvd;
  logic [RW-1:0]        rem;
  logic [lcw_pkg::CNT_W-1:0] cnt;

  function automatic logic [3:0] region(input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y,
                                        input logic signed [CW-1:0] xmn,
                                        input logic signed [CW-1:0] xmx,
                                        input logic signed [CW-1:0] ymn,
                                        input logic signed [CW-1:0] ymx);
    logic [3:0] c;
    c = 4'd0;
    if (y > ymx) c = c | lcw_pkg::CODE_TOP;
    else if (y < ymn) c = c | lcw_pkg::CODE_BOTTOM;
    if (x > xmx) c = c | lcw_pkg::CODE_RIGHT;
    else if (x < xmn) c = c | lcw_pkg::CODE_LEFT;
    return c;
  endfunction

  // Outcodes, choice of the endpoint and edge to move, and the magnitude product
  logic [3:0]           c0, c1, cout;
  logic                 first, vert;
  logic signed [CW-1:0] edge_v;
  logic signed [CW:0]   a_s, b_s, c_s;
  logic [CW:0]          a_m, b_m, c_m;
  logic [2*CW+1:0]      prod_full;

  always_comb begin
    c0    = region(x0, y0, wx_min, wx_max, wy_min, wy_max);
    c1    = region(x1, y1, wx_min, wx_max, wy_min, wy_max);
    first = (c0 != 4'd0);
    cout  = first ? c0 : c1;
    vert  = ((cout & (lcw_pkg::CODE_TOP | lcw_pkg::CODE_BOTTOM)) != 4'd0);
    if ((cout & lcw_pkg::CODE_TOP) != 4'd0)         edge_v = wy_max;
    else if ((cout & lcw_pkg::CODE_BOTTOM) != 4'd0) edge_v = wy_min;
    else if ((cout & lcw_pkg::CODE_RIGHT) != 4'd0)  edge_v = wx_max;
    else                                            edge_v = wx_min;
    if (vert) begin
      a_s = (CW+1)'(x1) - (CW+1)'(x0);
      b_s = (CW+1)'(edge_v) - (CW+1)'(y0);
      c_s = (CW+1)'(y1) - (CW+1)'(y0);
    end else begin
      a_s = (CW+1)'(y1) - (CW+1)'(y0);
      b_s = (CW+1)'(edge_v) - (CW+1)'(x0);
      c_s = (CW+1)'(x1) - (CW+1)'(x0);
    end
    a_m       = a_s[CW] ? (CW+1)'(-a_s) : (CW+1)'(a_s);
    b_m       = b_s[CW] ? (CW+1)'(-b_s) : (CW+1)'(b_s);
    c_m       = c_s[CW] ? (CW+1)'(-c_s) : (CW+1)'(c_s);
    prod_full = a_m * b_m;
  end

  // Divide step: shift in one dividend bit, subtract when it fits
  logic [RW-1:0] shifted;
  logic [RW-1:0] trial;
  always_comb begin
    shifted = {rem[RW-2:0], dvd[DW-1]};
    trial   = shifted - RW'(divisor);
  end

  // Intersection result: base plus signed quotient, saturated
  logic signed [DW:0]   qs;
  logic signed [DW+1:0] sum;
  logic signed [CW-1:0] sat_v;
  localparam logic signed [DW+1:0] SAT_HI = (DW+2)'((1 << (CW - 1)) - 1);
  localparam logic signed [DW+1:0] SAT_LO = -SAT_HI - (DW+2)'(1);
  always_comb begin
    qs  = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
    sum = (DW+2)'(base_r) + (DW+2)'(qs);
    if (sum > SAT_HI)      sat_v = SAT_HI[CW-1:0];
    else if (sum < SAT_LO) sat_v = SAT_LO[CW-1:0];
    else                   sat_v = sum[CW-1:0];
  end

  // Window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wx_min <= CW'(800);
      wx_max <= CW'(1600);
      wy_min <= CW'(800);
      wy_max <= CW'(1600);
    end else if (cfg_we) begin
      case (cfg_index)
        lcw_pkg::REG_X_MIN: wx_min <= cfg_data;
        lcw_pkg::REG_X_MAX: wx_max <= cfg_data;
        lcw_pkg::REG_Y_MIN: wy_min <= cfg_data;
        lcw_pkg::REG_Y_MAX: wy_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Endpoints, multiply, divide and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0 <= start_x;
      y0 <= start_y;
      x1 <= end_x;
      y1 <= end_y;
    end
    if (cmd.mul) begin
      prod    <= prod_full[DW-1:0];
      neg     <= a_s[CW] ^ b_s[CW] ^ c_s[CW];
      divisor <= c_m;
      base_r  <= vert ? x0 : y0;
      edge_r  <= edge_v;
      first_r <= first;
      vert_r  <= vert;
    end
    if (cmd.div_start) begin
      dvd <= prod;
      rem <= '0;
      cnt <= lcw_pkg::CNT_W'(DW);
    end
    if (cmd.div_step) begin
      cnt <= cnt - 1'b1;
      if (!trial[RW-1]) begin
        rem <= trial;
        dvd <= {dvd[DW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        dvd <= {dvd[DW-2:0], 1'b0};
      end
    end
    // Move the chosen endpoint onto the edge
    if (cmd.update) begin
      if (first_r) begin
        x0 <= vert_r ? sat_v : edge_r;
        y0 <= vert_r ? edge_r : sat_v;
      end else begin
        x1 <= vert_r ? sat_v : edge_r;
        y1 <= vert_r ? edge_r : sat_v;
      end
    end
    if (cmd.finish) begin
      accepted        <= cmd.accept;
      clipped_start_x <= cmd.accept ? x0 : '0;
      clipped_start_y <= cmd.accept ? y0 : '0;
      clipped_end_x   <= cmd.accept ? x1 : '0;
      clipped_end_y   <= cmd.accept ? y1 : '0;
    end
  end

  assign status.c0       = c0;
  assign status.c1       = c1;
  assign status.div_done = (cnt == '0);

endmodule

/* rtl/line_clip_to_window_unit.sv */
// ----------------------------------------------------------------------------
// line_clip_to_window_unit
// Clips one line segment against the rectangular window in its registers.
// ----------------------------------------------------------------------------
// One segment is taken at a time; in_stall stays high until its result has
// been taken. A segment is accepted or rejected outright or after intersection
// moves (at most four). Each move runs the restoring divider, which retires one
// quotient bit of the 32-bit product per cycle. Window registers are written
// through cfg_we/cfg_index/cfg_data (index 0..3: x min, x max, y min, y max);
// the user must write them only while the unit is idle, which the block itself
// does not enforce.
module line_clip_to_window_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lcw_pkg::IDX_W-1:0]       cfg_index,
  input  logic [lcw_pkg::CW-1:0]          cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [lcw_pkg::CW-1:0]   start_x,
  input  logic signed [lcw_pkg::CW-1:0]   start_y,
  input  logic signed [lcw_pkg::CW-1:0]   end_x,
  input  logic signed [lcw_pkg::CW-1:0]   end_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            accepted,
  output logic signed [lcw_pkg::CW-1:0]   clipped_start_x,
  output logic signed [lcw_pkg::CW-1:0]   clipped_start_y,
  output logic signed [lcw_pkg::CW-1:0]   clipped_end_x,
  output logic signed [lcw_pkg::CW-1:0]   clipped_end_y
);

  lcw_pkg::cmd_t    cmd;
  lcw_pkg::status_t status;

  lcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lcw_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start_x         (start_x),
    .start_y         (start_y),
    .end_x           (end_x),
    .end_y           (end_y),
    .cmd             (cmd),
    .status          (status),
    .accepted        (accepted),
    .clipped_start_x (clipped_start_x),
    .clipped_start_y (clipped_start_y),
    .clipped_end_x   (clipped_end_x),
    .clipped_end_y   (clipped_end_y)
  );

endmodule

/* bench/tb_line_clip_to_window_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_clip_to_window_unit
// Self-checking bench for the line clip to window unit.
// ----------------------------------------------------------------------------
// A queue of segments feeds a clocked driver. A clocked monitor compares each
// clipped result with a clip computed here from the bench's own copy of the
// window. The window is rewritten between phases, once the unit has drained:
// the reset window, random windows, the full coordinate range, a one-point
// window and inverted windows. Both sides idle at random but for the full range.
module tb_line_clip_to_window_unit;

  localparam int CW        = lcw_pkg::CW;
  localparam int IDX_W     = lcw_pkg::IDX_W;
  localparam int MAX_MOVES = lcw_pkg::MAX_MOVES;

  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey;
  } segment_t;

  typedef struct {
    logic                 acc;
    logic signed [CW-1:0] sx, sy, ex, ey;
  } clip_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CW-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 accepted;
  logic signed [CW-1:0] clipped_start_x, clipped_start_y;
  logic signed [CW-1:0] clipped_end_x, clipped_end_y;

  line_clip_to_window_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Window as seen by the clip calculation
  longint win_x_min = 800, win_x_max = 1600, win_y_min = 800, win_y_max = 1600;

  segment_t pending_segments[$];
  clip_t    expected_clips[$];
  int       mismatches = 0;
  int       send_gap_max = 4;
  int       recv_stall_max = 4;
  longint   cycles = 0;

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] code;
    code = '0;
    if (y > win_y_max) code |= lcw_pkg::CODE_TOP;
    else if (y < win_y_min) code |= lcw_pkg::CODE_BOTTOM;
    if (x > win_x_max) code |= lcw_pkg::CODE_RIGHT;
    else if (x < win_x_min) code |= lcw_pkg::CODE_LEFT;
    return code;
  endfunction

  // trunc(a * b / c) toward zero, sign taken from each operand; 0 if c is 0
  function automatic longint scaled_quotient(longint a, longint b, longint c);
    longint q;
    if (c == 0) return 0;
    q = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) / (c < 0 ? -c : c);
    if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
    return (((a < 0) != (b < 0)) != (c < 0)) ? -q : q;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic clip_t clip_segment(segment_t s);
    longint x0, y0, x1, y1, nx, ny;
    logic [3:0] c0, c1, cout;
    int moves;
    clip_t r;
    x0 = s.sx; y0 = s.sy; x1 = s.ex; y1 = s.ey;
    c0 = region_code(x0, y0);
    c1 = region_code(x1, y1);
    moves = 0;
    r = '{1'b0, '0, '0, '0, '0};
    forever begin
      if ((c0 | c1) == 0) begin
        r = '{1'b1, x0[CW-1:0], y0[CW-1:0], x1[CW-1:0], y1[CW-1:0]};
        break;
      end
      if ((c0 & c1) != 0 || moves == MAX_MOVES) break;
      cout = (c0 != 0) ? c0 : c1;
      if (cout & lcw_pkg::CODE_TOP) begin
        ny = win_y_max;
        nx = clamp_coord(x0 + scaled_quotient(x1 - x0, win_y_max - y0, y1 - y0));
      end else if (cout & lcw_pkg::CODE_BOTTOM) begin
        ny = win_y_min;
        nx = clamp_coord(x0 + scaled_quotient(x1 - x0, win_y_min - y0, y1 - y0));
      end else if (cout & lcw_pkg::CODE_RIGHT) begin
        nx = win_x_max;
        ny = clamp_coord(y0 + scaled_quotient(y1 - y0, win_x_max - x0, x1 - x0));
      end else begin
        nx = win_x_min;
        ny = clamp_coord(y0 + scaled_quotient(y1 - y0, win_x_min - x0, x1 - x0));
      end
      if (cout == c0) begin
        x0 = nx; y0 = ny; c0 = region_code(x0, y0);
      end else begin
        x1 = nx; y1 = ny; c1 = region_code(x1, y1);
      end
      moves++;
    end
    return r;
  endfunction

  // Driver: present the next segment after a random gap
  int send_gap = 0;
  always @(posedge clk) begin
    logic free;
    segment_t s;
    free = !in_valid;
    if (!rst && in_valid && !in_stall) begin
      expected_clips.push_back(clip_segment('{start_x, start_y, end_x, end_y}));
      free = 1'b1;
    end
    if (free) begin
      if (send_gap > 0 || rst || pending_segments.size() == 0) begin
        if (send_gap > 0 && !rst) send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else begin
        s = pending_segments.pop_front();
        start_x <= s.sx; start_y <= s.sy; end_x <= s.ex; end_y <= s.ey;
        in_valid <= 1'b1;
        send_gap <= $urandom_range(0, send_gap_max);
      end
    end
  end

  // Monitor: check each result against the oldest expected clip
  int recv_stall = 0;
  always @(posedge clk) begin
    clip_t e;
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("== FAIL ==");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_clips.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        e = expected_clips.pop_front();
        if (accepted !== e.acc || clipped_start_x !== e.sx || clipped_start_y !== e.sy ||
            clipped_end_x !== e.ex || clipped_end_y !== e.ey) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d (%0d,%0d)-(%0d,%0d) got %0d (%0d,%0d)-(%0d,%0d)",
                     e.acc, e.sx, e.sy, e.ex, e.ey, accepted, clipped_start_x,
                     clipped_start_y, clipped_end_x, clipped_end_y);
        end
      end
      recv_stall = $urandom_range(0, recv_stall_max);
    end else if (recv_stall > 0) begin
      recv_stall--;
    end
    out_stall <= (recv_stall > 0);
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lcw_pkg::REG_X_MIN: win_x_min = val;
      lcw_pkg::REG_X_MAX: win_x_max = val;
      lcw_pkg::REG_Y_MIN: win_y_min = val;
      lcw_pkg::REG_Y_MAX: win_y_max = val;
      default: ;
    endcase
  endtask

  task automatic set_window(longint x0, longint x1, longint y0, longint y1);
    write_reg(lcw_pkg::REG_X_MIN, x0);
    write_reg(lcw_pkg::REG_X_MAX, x1);
    write_reg(lcw_pkg::REG_Y_MIN, y0);
    write_reg(lcw_pkg::REG_Y_MAX, y1);
  endtask

  // Hold until every request has been taken and every clip has come back;
  // sample on the falling edge so the driver's updates have settled
  task automatic drain();
    while (pending_segments.size() != 0 || in_valid || expected_clips.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic longint pick_coord(longint lo, longint hi);
    longint a, b;
    if ($urandom_range(0, 2) == 0) return $signed(16'($urandom));
    a = (lo < hi ? lo : hi) - 300;
    b = (lo < hi ? hi : lo) + 300;
    return clamp_coord(a + $urandom_range(0, b - a));
  endfunction

  task automatic add(longint a, longint b, longint c, longint d);
    pending_segments.push_back('{a[CW-1:0], b[CW-1:0], c[CW-1:0], d[CW-1:0]});
  endtask

  task automatic random_segments(int n);
    repeat (n)
      add(pick_coord(win_x_min, win_x_max), pick_coord(win_y_min, win_y_max),
          pick_coord(win_x_min, win_x_max), pick_coord(win_y_min, win_y_max));
  endtask

  initial begin
    longint a, b, c, d;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset window: inside, outright rejects, each edge crossed, corners, extremes
    add(1000, 1000, 1200, 1400);
    add(0, 0, 100, 1600);
    add(1200, 1200, 1200, 2400);
    add(1200, 1200, 1200, 0);
    add(1200, 1200, 2400, 1200);
    add(1200, 1200, 0, 1200);
    add(1200, 2400, 1200, 1000);
    add(0, 1200, 2400, 1200);
    add(0, 0, 2400, 2400);
    add(0, 1500, 300, 2400);
    add(-32768, -32768, 32767, 32767);
    add(32767, -32768, -32768, 32767);
    add(1100, 1100, 1100, 1100);
    add(2000, 2000, 2000, 2000);
    add(800, 800, 1600, 1600);
    add(1600, 2000, 1600, 0);
    add(-32768, 1200, 32767, 1201);
    add(700, 2400, 2400, 700);
    drain();
    // Index past the last register must be ignored
    write_reg(8'd7, 0);
    add(1000, 1000, 1200, 1400);
    drain();

    random_segments(150);
    drain();

    // Full range window, no idling
    send_gap_max = 0; recv_stall_max = 0;
    set_window(-32768, 32767, -32768, 32767);
    random_segments(100);
    drain();
    send_gap_max = 4; recv_stall_max = 4;

    // Single-point window at the extremes
    set_window(32767, 32767, -32768, -32768);
    random_segments(60);
    drain();

    // Inverted window
    set_window(1600, 800, 1600, 800);
    add(1200, 1200, 1300, 1300);
    add(0, 0, 2400, 2400);
    random_segments(100);
    drain();

    // Random windows, some inverted
    repeat (6) begin
      a = $signed(16'($urandom)); b = a + $urandom_range(0, 4000);
      c = $signed(16'($urandom)); d = c + $urandom_range(0, 4000);
      if ($urandom_range(0, 3) == 0) set_window(clamp_coord(b), a, c, clamp_coord(d));
      else set_window(a, clamp_coord(b), c, clamp_coord(d));
      random_segments(110);
      drain();
    end

    if (mismatches == 0 && expected_clips.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
rtl/lcw_pkg.sv
rtl/lcw_ctrl.sv
rtl/lcw_dp.sv
rtl/line_clip_to_window_unit.sv
bench/tb_line_clip_to_window_unit.sv
